// ----- hw/rtl/epr_pkg.sv -----
// ----------------------------------------------------------------------------
// epr_pkg: shared types and constants of the Euler pose to matrix block
// CORDIC arctangent table and the pose record passed from front to back.
// ----------------------------------------------------------------------------
package epr_pkg;

	localparam int ANG_W = 16;
	localparam int SHF_W = 32;
	localparam int QTR   = 16384;
	localparam int ONE_Q14 = 16384;
	localparam longint CORDIC_GAIN_Q30 = 64'd652032874;

	typedef struct packed {
		logic signed [ANG_W-1:0] ax;
		logic signed [ANG_W-1:0] ay;
		logic signed [ANG_W-1:0] az;
		logic [SHF_W-1:0]        tx;
		logic [SHF_W-1:0]        ty;
		logic [SHF_W-1:0]        tz;
	} pose_t;

	function automatic logic [31:0] atan_turn(input int i);
		logic [31:0] t;
		unique case (i)
			0: t = 32'h20000000;  1: t = 32'h12E4051E;  2: t = 32'h09FB385B;
			3: t = 32'h051111D4;  4: t = 32'h028B0D43;  5: t = 32'h0145D7E1;
			6: t = 32'h00A2F61E;  7: t = 32'h00517C55;  8: t = 32'h0028BE53;
			9: t = 32'h00145F2F;  10: t = 32'h000A2F98; 11: t = 32'h000517CC;
			12: t = 32'h00028BE6; 13: t = 32'h000145F3; 14: t = 32'h0000A2FA;
			15: t = 32'h0000517D; 16: t = 32'h000028BE; 17: t = 32'h0000145F;
			18: t = 32'h00000A30; 19: t = 32'h00000518; 20: t = 32'h0000028C;
			21: t = 32'h00000146; 22: t = 32'h000000A3; 23: t = 32'h00000051;
			default: t = 32'h0;
		endcase
		return t;
	endfunction

endpackage

// ----- hw/rtl/epr_front.sv -----
// ----------------------------------------------------------------------------
// epr_front: pose intake and queue
// Registers incoming pose beats into a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module epr_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  epr_pkg::pose_t   in_pose,
	output logic             q_valid,
	input  logic             q_ready,
	output epr_pkg::pose_t   q_pose
);
	epr_pkg::pose_t mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	assign in_ready = (cnt_q != 2'd2);
	assign q_valid  = (cnt_q != 2'd0);
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_ready;
	assign q_pose   = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= in_pose;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

`ifndef SYNTHESIS
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("queue count overflow");
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2 && !pop) |=> cnt_q == 2'd2) else $error("queue lost entry");
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd0) |-> !pop) else $error("pop on empty");
`endif
endmodule

// ----- hw/rtl/epr_cordic.sv -----
// ----------------------------------------------------------------------------
// epr_cordic: sine and cosine in Q2.14 of one binary angle
// Fully pipelined rotation CORDIC, one micro-rotation per stage.
// ----------------------------------------------------------------------------
module epr_cordic #(
	parameter int TRIG_BITS = 16
) (
	input  logic               clk,
	input  logic signed [15:0] ang,
	output logic signed [15:0] sin_o,
	output logic signed [15:0] cos_o
);
	localparam int XW = TRIG_BITS + 3;
	localparam int D  = TRIG_BITS - 14;
	localparam logic signed [XW-1:0] X0 =
		XW'((epr_pkg::CORDIC_GAIN_Q30 + (64'sd1 <<< (29 - TRIG_BITS)))
			>>> (30 - TRIG_BITS));

	logic signed [XW-1:0] x_s [TRIG_BITS+1];
	logic signed [XW-1:0] y_s [TRIG_BITS+1];
	logic signed [33:0]   z_s [TRIG_BITS+1];
	logic                 f_s [TRIG_BITS+1];

	logic signed [16:0] a17;
	logic               flip0;
	always_comb begin
		a17 = 17'(ang); flip0 = 1'b0;
		if (ang > 16'sd16384) begin a17 = 17'(ang) - 17'sd32768; flip0 = 1'b1; end
		else if (ang < -16'sd16384) begin a17 = 17'(ang) + 17'sd32768; flip0 = 1'b1; end
	end

	assign x_s[0] = X0;
	assign y_s[0] = '0;
	assign z_s[0] = 34'(a17) <<< 16;
	assign f_s[0] = flip0;

	for (genvar i = 0; i < TRIG_BITS; i++) begin : g_st
		logic signed [XW-1:0] xn, yn;
		logic signed [33:0]   zn;
		always_comb begin
			if (z_s[i] >= 0) begin
				xn = x_s[i] - (y_s[i] >>> i);
				yn = y_s[i] + (x_s[i] >>> i);
				zn = z_s[i] - $signed({2'b00, epr_pkg::atan_turn(i)});
			end else begin
				xn = x_s[i] + (y_s[i] >>> i);
				yn = y_s[i] - (x_s[i] >>> i);
				zn = z_s[i] + $signed({2'b00, epr_pkg::atan_turn(i)});
			end
		end
		always_ff @(posedge clk) begin
			x_s[i+1] <= xn; y_s[i+1] <= yn; z_s[i+1] <= zn; f_s[i+1] <= f_s[i];
		end
	end

	function automatic logic signed [15:0] q14(input logic signed [XW-1:0] v, input logic f);
		logic signed [XW+14:0] r;
		if (D > 0) r = ((XW+15)'(v) + ((XW+15)'(1) <<< (D > 0 ? D-1 : 0))) >>> D;
		else r = (XW+15)'(v) <<< (-D);
		if (r > 16384) r = 16384;
		if (r < -16384) r = -16384;
		if (f) r = -r;
		return 16'(r);
	endfunction

	always_ff @(posedge clk) begin
		sin_o <= q14(y_s[TRIG_BITS], f_s[TRIG_BITS]);
		cos_o <= q14(x_s[TRIG_BITS], f_s[TRIG_BITS]);
	end
endmodule

// ----- hw/rtl/epr_back.sv -----
// ----------------------------------------------------------------------------
// epr_back: matrix build and row output
// Trig pipeline, product stages, then three row beats from a result queue.
// ----------------------------------------------------------------------------
module epr_back #(
	parameter int TRIG_BITS = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	output logic           q_ready,
	input  epr_pkg::pose_t q_pose,
	output logic           m_tvalid,
	input  logic           m_tready,
	output logic [81:0]    m_tdata,
	output logic           m_tlast
);
	localparam int LAT = TRIG_BITS + 4;
	localparam int QD  = 16;
	localparam int PW  = $clog2(QD);

	logic signed [15:0] sx, cx, sy, cy, sz, cz;
	logic [LAT-1:0] v_q;
	logic [95:0]    t_q [LAT];
	logic [PW:0]    cred_q;
	logic           take;

	assign take = q_valid && q_ready;

	epr_cordic #(.TRIG_BITS(TRIG_BITS)) u_cx (.clk, .ang(q_pose.ax), .sin_o(sx), .cos_o(cx));
	epr_cordic #(.TRIG_BITS(TRIG_BITS)) u_cy (.clk, .ang(q_pose.ay), .sin_o(sy), .cos_o(cy));
	epr_cordic #(.TRIG_BITS(TRIG_BITS)) u_cz (.clk, .ang(q_pose.az), .sin_o(sz), .cos_o(cz));

	always_ff @(posedge clk) begin
		t_q[0] <= {q_pose.tz, q_pose.ty, q_pose.tx};
		for (int i = 1; i < LAT; i++) t_q[i] <= t_q[i-1];
	end

	// stage 2: pair products Q28
	logic signed [31:0] czsx_s2, cxsz_s2, cxcz_s2, sxsz_s2, cysz_s2, cycz_s2;
	logic signed [31:0] sxsy_s2, cxsy_s2, cysx_s2, cxcy_s2;
	logic signed [15:0] sy_s2, sz_s2;
	always_ff @(posedge clk) begin
		czsx_s2 <= cz * sx; cxsz_s2 <= cx * sz; cxcz_s2 <= cx * cz;
		sxsz_s2 <= sx * sz; cysz_s2 <= cy * sz; cycz_s2 <= cy * cz;
		sxsy_s2 <= sx * sy; cxsy_s2 <= cx * sy;
		cysx_s2 <= cy * sx; cxcy_s2 <= cx * cy;
		sy_s2 <= sy; sz_s2 <= sz;
	end

	// stage 3: triple terms Q42
	logic signed [47:0] p01_s3, p02_s3, p11_s3, p12_s3;
	logic signed [31:0] czsx_s3, cxsz_s3, cxcz_s3, sxsz_s3;
	logic signed [31:0] cysz_s3, cycz_s3, cysx_s3, cxcy_s3;
	logic signed [15:0] sy_s3;
	always_ff @(posedge clk) begin
		p01_s3 <= czsx_s2 * sy_s2; p02_s3 <= cxcz_s2 * sy_s2;
		p11_s3 <= sxsy_s2 * sz_s2; p12_s3 <= cxsy_s2 * sz_s2;
		czsx_s3 <= czsx_s2; cxsz_s3 <= cxsz_s2; cxcz_s3 <= cxcz_s2; sxsz_s3 <= sxsz_s2;
		cysz_s3 <= cysz_s2; cycz_s3 <= cycz_s2; cysx_s3 <= cysx_s2; cxcy_s3 <= cxcy_s2;
		sy_s3 <= sy_s2;
	end

	function automatic logic [15:0] ent(input logic signed [49:0] v);
		logic signed [49:0] r;
		r = (v + (50'sd1 <<< 27)) >>> 28;
		if (r > 32767) r = 32767;
		if (r < -32768) r = -32768;
		return 16'(r);
	endfunction

	function automatic logic signed [49:0] up(input logic signed [31:0] v);
		return 50'(v) <<< 14;
	endfunction

	logic [47:0] r0_s4, r1_s4, r2_s4;
	logic [16:0] nsy;
	always_comb nsy = -17'(sy_s3);
	always_ff @(posedge clk) begin
		r0_s4 <= {ent(50'(p02_s3) + up(sxsz_s3)), ent(50'(p01_s3) - up(cxsz_s3)),
			ent(up(cycz_s3))};
		r1_s4 <= {ent(50'(p12_s3) - up(czsx_s3)), ent(up(cxcz_s3) + 50'(p11_s3)),
			ent(up(cysz_s3))};
		r2_s4 <= {ent(up(cxcy_s3)), ent(up(cysx_s3)),
			(nsy == 17'd32768) ? 16'h7FFF : nsy[15:0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_q <= '0;
		else v_q <= {v_q[LAT-2:0], take};
	end

	// result queue of whole matrices; credits bound items in flight
	logic [143:0]  rm_q [QD];
	logic [95:0]   rt_q [QD];
	logic [PW-1:0] wp_q, rp_q;
	logic [1:0]    row_q;
	logic [PW:0]   cnt_q;
	logic          done;

	assign q_ready = (cred_q != '0);
	assign done = m_tvalid && m_tready && (row_q == 2'd2);

	always_ff @(posedge clk) begin
		if (v_q[LAT-1]) begin
			rm_q[wp_q] <= {r2_s4, r1_s4, r0_s4};
			rt_q[wp_q] <= t_q[LAT-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cred_q <= (PW+1)'(QD); wp_q <= '0; rp_q <= '0; row_q <= '0; cnt_q <= '0;
		end else begin
			cred_q <= cred_q - {{PW{1'b0}}, take} + {{PW{1'b0}}, done};
			cnt_q  <= cnt_q + {{PW{1'b0}}, v_q[LAT-1]} - {{PW{1'b0}}, done};
			if (v_q[LAT-1]) wp_q <= wp_q + PW'(1);
			if (m_tvalid && m_tready) begin
				if (row_q == 2'd2) begin row_q <= 2'd0; rp_q <= rp_q + PW'(1); end
				else row_q <= row_q + 2'd1;
			end
		end
	end

	logic [47:0] row;
	logic [31:0] tr;
	always_comb begin
		unique case (row_q)
			2'd0: begin row = rm_q[rp_q][47:0];   tr = rt_q[rp_q][31:0];  end
			2'd1: begin row = rm_q[rp_q][95:48];  tr = rt_q[rp_q][63:32]; end
			default: begin row = rm_q[rp_q][143:96]; tr = rt_q[rp_q][95:64]; end
		endcase
	end

	assign m_tvalid = (cnt_q != '0);
	assign m_tlast  = (row_q == 2'd2);
	assign m_tdata  = {tr, row, row_q};

`ifndef SYNTHESIS
	a_cred: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, cred_q} + {1'b0, cnt_q}) <= (PW+2)'(QD)) else $error("credit mismatch");
	a_row: assert property (@(posedge clk) disable iff (!arst_n) row_q != 2'd3)
		else $error("bad row");
	a_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		v_q[LAT-1] |-> cnt_q != (PW+1)'(QD) || done) else $error("result queue overflow");
`endif
endmodule

// ----- hw/rtl/euler_pose_to_rigid_matrix_unit.sv -----
// ----------------------------------------------------------------------------
// euler_pose_to_rigid_matrix_unit: Z-Y-X Euler pose to 3x4 rigid matrix
// Emits rows of [Rz*Ry*Rx | t], three beats per pose.
// ----------------------------------------------------------------------------
// Path: pose beat through the queue, CORDIC stages, two product stages and the
//   rounding stage into the result queue, then out as the first row beat.
// Output: three row beats per pose on the output port bound the pose rate;
//   CORDIC units are pipelined and take a pose each cycle while credits remain.
// Reset: arst_n clears pointers and valid flags, fills credits; no stored data.
module euler_pose_to_rigid_matrix_unit #(
	parameter int TRIG_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// angle_x[15:0], angle_y[31:16], angle_z[47:32], shift_x[79:48],
	// shift_y[111:80], shift_z[143:112]
	input  logic [143:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// row_index[1:0], col0[17:2], col1[33:18], col2[49:34], col3[81:50], pad
	output logic [87:0]  m_tdata,
	output logic         m_tlast
);
	epr_pkg::pose_t in_pose, q_pose;
	logic q_valid, q_ready;
	logic [81:0] dat;

	assign in_pose = '{ax: s_tdata[15:0], ay: s_tdata[31:16], az: s_tdata[47:32],
		tx: s_tdata[79:48], ty: s_tdata[111:80], tz: s_tdata[143:112]};

	epr_front u_front (
		.clk, .arst_n, .in_valid(s_tvalid), .in_ready(s_tready), .in_pose,
		.q_valid, .q_ready, .q_pose
	);

	epr_back #(.TRIG_BITS(TRIG_BITS)) u_back (
		.clk, .arst_n, .q_valid, .q_ready, .q_pose,
		.m_tvalid, .m_tready, .m_tdata(dat), .m_tlast
	);

	assign m_tdata = {6'd0, dat};
endmodule

// ----- test/euler_pose_to_rigid_matrix_unit_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// euler_pose_to_rigid_matrix_unit_test: self-checking bench for the pose unit
// Drives poses on the slave stream, rebuilds each expected 3x4 row with a
// local CORDIC/matrix predictor and compares every master beat against it,
// under three sender/receiver idling mixes plus a long output hold-off.
// ----------------------------------------------------------------------------
module euler_pose_to_rigid_matrix_unit_test;

	localparam int TRIG_BITS = 16;
	localparam int HALF_PERIOD = 5;
	localparam int CYCLE_LIMIT = 400000;
	localparam int RAND_PER_PHASE = 70;

	// arctangent of 2^-i, 2^32 per turn
	localparam longint ATAN_TURN [0:23] = '{
		64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
		64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
		64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
		64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D,
		64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
		64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
	};

	// one expected row beat
	typedef struct {
		logic [1:0]         row;
		logic signed [15:0] c0;
		logic signed [15:0] c1;
		logic signed [15:0] c2;
		logic [31:0]        c3;
		logic               last;
	} row_beat_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	// angle_x, angle_y, angle_z, shift_x, shift_y, shift_z from bit 0 up
	logic [143:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	// row_index, col0, col1, col2, col3, pad from bit 0 up
	logic [87:0]  m_tdata;
	logic         m_tlast;

	row_beat_t    rows_due[$];
	int           err_count;
	int           cycle_count;
	int           send_idle_pct;
	int           recv_idle_pct;
	int           hold_cycles;

	euler_pose_to_rigid_matrix_unit #(.TRIG_BITS(TRIG_BITS)) dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	always #HALF_PERIOD clk = ~clk;

	// ---------------- predictor ----------------
	function automatic longint round_half_up(input longint v, input int s);
		if (s == 0) return v;
		return (v + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	function automatic longint trig_to_q14(input longint v);
		longint r;
		if (TRIG_BITS >= 14) r = round_half_up(v, TRIG_BITS - 14);
		else r = v <<< (14 - TRIG_BITS);
		if (r > epr_pkg::ONE_Q14) r = epr_pkg::ONE_Q14;
		if (r < -epr_pkg::ONE_Q14) r = -epr_pkg::ONE_Q14;
		return r;
	endfunction

	// rotation-mode CORDIC with half-turn folding
	task automatic cordic_sin_cos(input logic signed [15:0] ang_in,
			output longint s, output longint c);
		longint ang, x, y, z, nx;
		bit     flip;
		ang = ang_in;
		flip = 0;
		if (ang > epr_pkg::QTR) begin
			ang -= 32768;
			flip = 1;
		end else if (ang < -epr_pkg::QTR) begin
			ang += 32768;
			flip = 1;
		end
		z = ang * 65536;
		x = round_half_up(epr_pkg::CORDIC_GAIN_Q30, 30 - TRIG_BITS);
		y = 0;
		for (int i = 0; i < TRIG_BITS; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				z -= ATAN_TURN[i];
			end else begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				z += ATAN_TURN[i];
			end
			x = nx;
		end
		x = trig_to_q14(x);
		y = trig_to_q14(y);
		if (flip) begin
			x = -x;
			y = -y;
		end
		s = y;
		c = x;
	endtask

	// Q42 sum to saturated Q14
	function automatic logic signed [15:0] q42_entry(input longint v);
		longint r;
		r = round_half_up(v, 28);
		if (r > 32767) r = 32767;
		if (r < -32768) r = -32768;
		return r[15:0];
	endfunction

	task automatic predict_rows(input epr_pkg::pose_t p);
		longint sx, cx, sy, cy, sz, cz;
		logic signed [15:0] m [0:2][0:2];
		logic [31:0] t [0:2];
		row_beat_t b;
		cordic_sin_cos(p.ax, sx, cx);
		cordic_sin_cos(p.ay, sy, cy);
		cordic_sin_cos(p.az, sz, cz);
		m[0][0] = q42_entry(cy * cz * epr_pkg::ONE_Q14);
		m[0][1] = q42_entry(cz * sx * sy - cx * sz * epr_pkg::ONE_Q14);
		m[0][2] = q42_entry(cx * cz * sy + sx * sz * epr_pkg::ONE_Q14);
		m[1][0] = q42_entry(cy * sz * epr_pkg::ONE_Q14);
		m[1][1] = q42_entry(cx * cz * epr_pkg::ONE_Q14 + sx * sy * sz);
		m[1][2] = q42_entry(cx * sy * sz - cz * sx * epr_pkg::ONE_Q14);
		m[2][0] = 16'(-sy);  // -sin(y) exactly, never beyond one
		m[2][1] = q42_entry(cy * sx * epr_pkg::ONE_Q14);
		m[2][2] = q42_entry(cx * cy * epr_pkg::ONE_Q14);
		t[0] = p.tx;
		t[1] = p.ty;
		t[2] = p.tz;
		for (int r = 0; r < 3; r++) begin
			b.row = 2'(r);
			b.c0 = m[r][0];
			b.c1 = m[r][1];
			b.c2 = m[r][2];
			b.c3 = t[r];
			b.last = (r == 2);
			rows_due.push_back(b);
		end
	endtask

	// ---------------- checking ----------------
	task automatic report_mismatch(input string what, input longint got,
			input longint want);
		$display("MISMATCH %s: got %0d expected %0d at cycle %0d",
			what, got, want, cycle_count);
		err_count++;
	endtask

	always @(posedge clk) begin
		row_beat_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (rows_due.size() == 0) begin
				$display("MISMATCH unexpected row beat at cycle %0d", cycle_count);
				err_count++;
			end else begin
				e = rows_due.pop_front();
				if (m_tdata[1:0] !== e.row)
					report_mismatch("row_index", m_tdata[1:0], e.row);
				if ($signed(m_tdata[17:2]) !== e.c0)
					report_mismatch("col0", $signed(m_tdata[17:2]), e.c0);
				if ($signed(m_tdata[33:18]) !== e.c1)
					report_mismatch("col1", $signed(m_tdata[33:18]), e.c1);
				if ($signed(m_tdata[49:34]) !== e.c2)
					report_mismatch("col2", $signed(m_tdata[49:34]), e.c2);
				if (m_tdata[81:50] !== e.c3)
					report_mismatch("col3", m_tdata[81:50], e.c3);
				if (m_tlast !== e.last)
					report_mismatch("last_row", m_tlast, e.last);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// receiver: random stalls, or a long hold-off when asked
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// ---------------- stimulus ----------------
	// one pose beat; tvalid stays high into the next beat unless the sender idles
	task automatic send_pose(input epr_pkg::pose_t p);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {p.tz, p.ty, p.tx, p.az, p.ay, p.ax};
		do @(posedge clk); while (!s_tready);
		predict_rows(p);
		@(negedge clk);
	endtask

	function automatic epr_pkg::pose_t random_pose();
		epr_pkg::pose_t p;
		p.ax = 16'($urandom);
		p.ay = 16'($urandom);
		p.az = 16'($urandom);
		p.tx = $urandom;
		p.ty = $urandom;
		p.tz = $urandom;
		// bias some angles onto the fold points at quarter turns and onto the half turn
		if ($urandom_range(7) == 0) p.ax = 16'($urandom_range(16383, 16386));
		if ($urandom_range(7) == 0) p.ay = -16'($urandom_range(16383, 16386));
		if ($urandom_range(7) == 0) p.az = 16'($urandom_range(32765, 32768));
		return p;
	endfunction

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (rows_due.size() != 0) @(posedge clk);
		repeat (TRIG_BITS + 10) @(posedge clk);
	endtask

	// directed poses: zero, angle extremes, fold edges, translation extremes
	epr_pkg::pose_t pose_tab [] = '{
		'{16'sd0, 16'sd0, 16'sd0, 32'h0, 32'h0, 32'h0},
		'{-16'sd32768, 16'sd0, 16'sd0, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF},
		'{16'sd32767, 16'sd32767, 16'sd32767, 32'h80000000, 32'h7FFFFFFF, 32'h1},
		'{-16'sd32768, -16'sd32768, -16'sd32768, 32'hFFFFFFFF, 32'h0, 32'h00010000},
		'{16'sd16384, 16'sd0, 16'sd0, 32'h0, 32'h0, 32'h0},
		'{16'sd16385, 16'sd0, 16'sd0, 32'h0, 32'h0, 32'h0},
		'{-16'sd16384, 16'sd0, 16'sd0, 32'h0, 32'h0, 32'h0},
		'{-16'sd16385, 16'sd0, 16'sd0, 32'h0, 32'h0, 32'h0},
		'{16'sd0, 16'sd16384, 16'sd0, 32'h0, 32'h0, 32'h0},
		'{16'sd0, -16'sd16384, 16'sd0, 32'h0, 32'h0, 32'h0},
		'{16'sd0, 16'sd16385, 16'sd0, 32'h0, 32'h0, 32'h0},
		'{16'sd0, 16'sd0, 16'sd16384, 32'h0, 32'h0, 32'h0},
		'{16'sd0, 16'sd0, -16'sd16385, 32'h0, 32'h0, 32'h0},
		'{16'sd8192, 16'sd8192, 16'sd8192, 32'h12345678, 32'h9ABCDEF0, 32'h0F0F0F0F},
		'{-16'sd8192, 16'sd24576, -16'sd24576, 32'hAAAAAAAA, 32'h55555555, 32'hCCCCCCCC},
		'{16'sd1, -16'sd1, 16'sd1, 32'h0, 32'h0, 32'h0},
		'{16'sd16384, 16'sd16384, 16'sd16384, 32'h0, 32'h0, 32'h0},
		'{16'sd32767, -16'sd32768, 16'sd16383, 32'h0, 32'h0, 32'h0}
	};

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		err_count = 0;
		cycle_count = 0;
		hold_cycles = 0;
		send_idle_pct = 17;
		recv_idle_pct = 63;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// phase 1: slow receiver
		foreach (pose_tab[i]) send_pose(pose_tab[i]);
		for (int i = 0; i < RAND_PER_PHASE; i++) send_pose(random_pose());

		// sender pauses until the pipe is empty
		wait_drained();

		// phase 2: slow sender
		send_idle_pct = 63;
		recv_idle_pct = 17;
		for (int i = 0; i < RAND_PER_PHASE; i++) send_pose(random_pose());

		// phase 3: no idling; long receiver hold-off fills the unit
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_cycles = 150;
		for (int i = 0; i < RAND_PER_PHASE; i++) send_pose(random_pose());

		wait_drained();
		if (err_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
